/* rtl/pdgc_pkg.sv */
// Shared types and constants for the divisor-gain PID controller.
package pdgc_pkg;

    localparam int GAIN_W    = 15;
    localparam int DRIVE_W   = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [DRIVE_W-1:0] OUT_MAX_RST = 16'sd127;
    localparam logic signed [DRIVE_W-1:0] OUT_MIN_RST = -16'sd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP     = 4'd0,
        REG_KI     = 4'd1,
        REG_KD     = 4'd2,
        REG_OUTMAX = 4'd3,
        REG_OUTMIN = 4'd4,
        REG_SPAN   = 4'd5,
        REG_SETPT  = 4'd6,
        REG_RUN    = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]         kp_divisor;
        logic [GAIN_W-1:0]         ki_divisor;
        logic [GAIN_W-1:0]         kd_divisor;
        logic signed [DRIVE_W-1:0] out_max;
        logic signed [DRIVE_W-1:0] out_min;
        logic [15:0]               input_span;
        logic signed [15:0]        setpoint;
        logic                      run_enable;
    } t_cfg;

    typedef enum logic [1:0] {
        DIV_P = 2'd0,
        DIV_I = 2'd1,
        DIV_D = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     wrap;
        logic     trial;
        logic     mul_step;
        logic     upd;
        logic     div_ld;
        t_div_sel div_sel;
        logic     div_step;
        logic     acc_add;
        logic     fin;
        logic     out_ld;
        logic     out_zero;
    } t_cmd;

    typedef struct packed {
        logic mul_last;
        logic div_last;
    } t_status;

endpackage

/* rtl/pdgc_regs.sv */
// Configuration register file, written through the plain write port.
module pdgc_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pdgc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pdgc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output pdgc_pkg::t_cfg                      o_cfg
);

    pdgc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_divisor <= '0;
            r_cfg.ki_divisor <= '0;
            r_cfg.kd_divisor <= '0;
            r_cfg.out_max    <= pdgc_pkg::OUT_MAX_RST;
            r_cfg.out_min    <= pdgc_pkg::OUT_MIN_RST;
            r_cfg.input_span <= '0;
            r_cfg.setpoint   <= '0;
            r_cfg.run_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (pdgc_pkg::t_reg_idx'(i_cfg_index))
                pdgc_pkg::REG_KP:     r_cfg.kp_divisor <= i_cfg_data[pdgc_pkg::GAIN_W-1:0];
                pdgc_pkg::REG_KI:     r_cfg.ki_divisor <= i_cfg_data[pdgc_pkg::GAIN_W-1:0];
                pdgc_pkg::REG_KD:     r_cfg.kd_divisor <= i_cfg_data[pdgc_pkg::GAIN_W-1:0];
                pdgc_pkg::REG_OUTMAX: r_cfg.out_max    <= $signed(i_cfg_data);
                pdgc_pkg::REG_OUTMIN: r_cfg.out_min    <= $signed(i_cfg_data);
                pdgc_pkg::REG_SPAN:   r_cfg.input_span <= i_cfg_data;
                pdgc_pkg::REG_SETPT:  r_cfg.setpoint   <= $signed(i_cfg_data);
                pdgc_pkg::REG_RUN:    r_cfg.run_enable <= i_cfg_data[0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/pdgc_ctrl.sv */
// Sequencer: steps the datapath through error, integrator update and three divisions.
module pdgc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic               i_run_enable,
    input  pdgc_pkg::t_status  i_status,
    output pdgc_pkg::t_cmd     o_cmd
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_WRAP  = 12'b0000_0000_0010,
        ST_TRIAL = 12'b0000_0000_0100,
        ST_MUL   = 12'b0000_0000_1000,
        ST_UPD   = 12'b0000_0001_0000,
        ST_DIVP  = 12'b0000_0010_0000,
        ST_LDI   = 12'b0000_0100_0000,
        ST_DIVI  = 12'b0000_1000_0000,
        ST_LDD   = 12'b0001_0000_0000,
        ST_DIVD  = 12'b0010_0000_0000,
        ST_FIN   = 12'b0100_0000_0000,
        ST_HOLD  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_bypass, n_bypass;
    logic   out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_bypass    = r_bypass;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.div_sel = pdgc_pkg::DIV_P;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_run_enable) begin
                        o_cmd.capture = 1'b1;
                        n_bypass      = 1'b0;
                        n_state       = ST_WRAP;
                    end else begin
                        n_bypass = 1'b1;
                        n_state  = ST_HOLD;
                    end
                end
            end
            ST_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = ST_TRIAL;
            end
            ST_TRIAL: begin
                o_cmd.trial = 1'b1;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_last) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.upd     = 1'b1;
                o_cmd.div_ld  = 1'b1;
                o_cmd.div_sel = pdgc_pkg::DIV_P;
                n_state       = ST_DIVP;
            end
            ST_DIVP: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_LDI;
                end
            end
            ST_LDI: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.div_ld  = 1'b1;
                o_cmd.div_sel = pdgc_pkg::DIV_I;
                n_state       = ST_DIVI;
            end
            ST_DIVI: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_LDD;
                end
            end
            ST_LDD: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.div_ld  = 1'b1;
                o_cmd.div_sel = pdgc_pkg::DIV_D;
                n_state       = ST_DIVD;
            end
            ST_DIVD: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.fin     = 1'b1;
                n_state       = ST_HOLD;
            end
            ST_HOLD: begin
                // wait until the output register can take the result
                if (out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_zero = r_bypass;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_bypass    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bypass    <= n_bypass;
        end
    end

endmodule

/* rtl/pdgc_dp.sv */
// Datapath: error wrap, serial anti-windup multiply, shared restoring divider, clamp.
module pdgc_dp #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int SUM_WIDTH    = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  pdgc_pkg::t_cmd                          i_cmd,
    input  pdgc_pkg::t_cfg                          i_cfg,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_measurement,
    output pdgc_pkg::t_status                       o_status,
    output logic signed [pdgc_pkg::DRIVE_W-1:0]     o_drive
);

    localparam int GW  = pdgc_pkg::GAIN_W;
    localparam int EW  = SAMPLE_WIDTH + 1;                       // wrapped error
    localparam int DFW = SAMPLE_WIDTH + 2;                       // error difference
    localparam int TRW = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1; // integrator trial
    localparam int PW  = TRW + GW;                               // windup product
    localparam int DW  = (SUM_WIDTH > DFW) ? SUM_WIDTH : DFW;    // divider dividend
    localparam int TW  = DW + 2;                                 // drive accumulator
    localparam int CW  = $clog2(DW + 1);
    localparam int MCW = $clog2(GW + 1);
    localparam int SH_P = DW - EW;
    localparam int SH_I = DW - SUM_WIDTH;
    localparam int SH_D = DW - DFW;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic signed [EW-1:0]        r_err, r_prev;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [TRW-1:0]       r_trial;
    logic signed [PW-1:0]        r_mcand, r_prod;
    logic [GW-1:0]               r_mplier;
    logic [MCW-1:0]              r_mcnt;
    logic [DW-1:0]               r_quo;
    logic [GW-1:0]               r_rem, r_den;
    logic                        r_neg;
    logic [CW-1:0]               r_dcnt;
    logic signed [TW-1:0]        r_total;
    logic signed [pdgc_pkg::DRIVE_W-1:0] r_drive;

    logic signed [SAMPLE_WIDTH-1:0] sp_s;
    logic [SAMPLE_WIDTH-1:0]        span_s;
    logic [EW-1:0]                  span_e, half, err_abs;
    logic signed [EW-1:0]           span_sg, wrapped;
    logic signed [TRW-1:0]          trial_sum;
    logic                           windup_ok;
    logic signed [SUM_WIDTH-1:0]    sum_sat;
    logic signed [DFW-1:0]          diff;
    logic signed [DW-1:0]           num;
    logic [DW-1:0]                  mag, quo_ld;
    logic [GW-1:0]                  den_ld;
    logic [CW-1:0]                  cnt_ld;
    logic [GW:0]                    div_t;
    logic                           div_ge;
    logic signed [TW-1:0]           q_ext, out_hi, out_lo;
    logic signed [pdgc_pkg::DRIVE_W-1:0] clamped;

    // error wrap for continuous input
    assign sp_s    = SAMPLE_WIDTH'($signed(i_cfg.setpoint));
    assign span_s  = SAMPLE_WIDTH'(i_cfg.input_span);
    assign span_e  = EW'(span_s);
    assign span_sg = $signed(span_e);
    assign half    = span_e >> 1;
    assign err_abs = r_err[EW-1] ? EW'(-r_err) : EW'(r_err);
    assign wrapped = (err_abs > half) ? (r_err[EW-1] ? r_err + span_sg : r_err - span_sg)
                                      : r_err;

    assign trial_sum = TRW'(r_sum) + TRW'(r_err);

    assign windup_ok = (r_prod < PW'($signed(i_cfg.out_max))) &&
                       (r_prod > PW'($signed(i_cfg.out_min)));

    always_comb begin
        if (r_trial > TRW'(SUM_MAX)) begin
            sum_sat = SUM_MAX;
        end else if (r_trial < TRW'(SUM_MIN)) begin
            sum_sat = SUM_MIN;
        end else begin
            sum_sat = SUM_WIDTH'(r_trial);
        end
    end

    // divider operand select; magnitude is left-aligned so each divide runs only its width
    assign diff = DFW'(r_err) - DFW'(r_prev);

    always_comb begin
        unique case (i_cmd.div_sel)
            pdgc_pkg::DIV_P: begin
                num    = DW'(r_err);
                den_ld = i_cfg.kp_divisor;
                cnt_ld = CW'(EW);
            end
            pdgc_pkg::DIV_I: begin
                num    = DW'(r_sum);
                den_ld = i_cfg.ki_divisor;
                cnt_ld = CW'(SUM_WIDTH);
            end
            pdgc_pkg::DIV_D: begin
                num    = DW'(diff);
                den_ld = i_cfg.kd_divisor;
                cnt_ld = CW'(DFW);
            end
            default: begin
                num    = '0;
                den_ld = '0;
                cnt_ld = '0;
            end
        endcase
    end

    assign mag = num[DW-1] ? DW'(-num) : DW'(num);

    always_comb begin
        unique case (i_cmd.div_sel)
            pdgc_pkg::DIV_P: quo_ld = mag << SH_P;
            pdgc_pkg::DIV_I: quo_ld = mag << SH_I;
            pdgc_pkg::DIV_D: quo_ld = mag << SH_D;
            default:         quo_ld = '0;
        endcase
    end

    assign div_t  = {r_rem, r_quo[DW-1]};
    assign div_ge = (div_t >= {1'b0, r_den});

    assign q_ext  = $signed(TW'(r_quo));
    assign out_hi = TW'($signed(i_cfg.out_max));
    assign out_lo = TW'($signed(i_cfg.out_min));

    always_comb begin
        if (r_total > out_hi) begin
            clamped = i_cfg.out_max;
        end else if (r_total < out_lo) begin
            clamped = i_cfg.out_min;
        end else begin
            clamped = pdgc_pkg::DRIVE_W'(r_total);
        end
    end

    // controller-visible state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_sum  <= '0;
            r_mcnt <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.upd && windup_ok) begin
                r_sum <= sum_sat;
            end
            if (i_cmd.fin) begin
                r_prev <= r_err;
            end
            if (i_cmd.trial) begin
                r_mcnt <= MCW'(GW);
            end else if (i_cmd.mul_step) begin
                r_mcnt <= r_mcnt - MCW'(1);
            end
            if (i_cmd.div_ld) begin
                r_dcnt <= cnt_ld;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt - CW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_err   <= EW'(sp_s) - EW'(i_measurement);
            r_total <= '0;
        end
        if (i_cmd.wrap) begin
            r_err <= wrapped;
        end
        if (i_cmd.trial) begin
            r_trial  <= trial_sum;
            r_mcand  <= PW'(trial_sum);
            r_prod   <= '0;
            r_mplier <= i_cfg.ki_divisor;
        end
        if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
        // accumulate the finished quotient before the next load overwrites it
        if (i_cmd.acc_add && (r_den != '0)) begin
            r_total <= r_neg ? r_total - q_ext : r_total + q_ext;
        end
        if (i_cmd.div_ld) begin
            r_quo <= quo_ld;
            r_rem <= '0;
            r_den <= den_ld;
            r_neg <= num[DW-1];
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[DW-2:0], div_ge};
            r_rem <= div_ge ? GW'(div_t - {1'b0, r_den}) : GW'(div_t);
        end
        if (i_cmd.out_ld) begin
            r_drive <= i_cmd.out_zero ? '0 : clamped;
        end
    end

    assign o_status.mul_last = (r_mcnt == MCW'(1));
    assign o_status.div_last = (r_dcnt == CW'(1));
    assign o_drive = r_drive;

endmodule

/* rtl/pid_divisor_gain_controller.sv */
// PID controller with divisor gains, continuous-input wrap and anti-windup integrator.
// Each request runs error wrap, a serial windup multiply, then three bit-serial divides
//   on one shared divider; a new request is taken only once the previous result is loaded.
// Disabled requests skip the computation and yield a zero drive.
// A finished result waits in the output register while the next request is taken.
// Synchronous active-low reset: gains 0, limits +127/-127, disabled, integrator cleared.
module pid_divisor_gain_controller #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int SUM_WIDTH    = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_measurement,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [pdgc_pkg::DRIVE_W-1:0]     o_drive,
    input  logic                                    i_cfg_we,
    input  logic [pdgc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pdgc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    pdgc_pkg::t_cfg    cfg;
    pdgc_pkg::t_cmd    cmd;
    pdgc_pkg::t_status status;

    pdgc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pdgc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_run_enable (cfg.run_enable),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    pdgc_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SUM_WIDTH    (SUM_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_measurement (i_measurement),
        .o_status      (status),
        .o_drive       (o_drive)
    );

`ifndef NO_ASSERTIONS
    // one request in flight: an accepted request closes the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one still in work");

    // result is never loaded over an untaken one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_ld |-> (!o_out_valid || !i_out_stall))
        else $error("output register loaded while holding a stalled result");

    // datapath commands that touch shared units never overlap
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.capture, cmd.trial, cmd.mul_step, cmd.div_ld, cmd.div_step,
                  cmd.out_ld}))
        else $error("conflicting datapath commands");

    // a divide step always follows a load or another step
    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.div_step && !$past(cmd.div_step)) |-> $past(cmd.div_ld))
        else $error("divider stepped without load");
`endif

endmodule

/* tb/tb_pid_divisor_gain_controller.sv */
// Self-checking testbench for the divisor-gain PID controller.
`timescale 1ns / 1ps

module tb_pid_divisor_gain_controller;

    localparam int DRAIN_CYCLES = 2*16 + 32 + 25 + 10;
    localparam int HOLD_CYCLES  = 800;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 105;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } t_stall_mode;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_stall;
    logic signed [15:0]                    i_measurement = '0;
    logic                                  o_out_valid;
    logic                                  i_out_stall = 1'b0;
    logic signed [pdgc_pkg::DRIVE_W-1:0]   o_drive;
    logic                                  i_cfg_we = 1'b0;
    logic [pdgc_pkg::CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [pdgc_pkg::CFG_DATA_W-1:0]       i_cfg_data = '0;

    pid_divisor_gain_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_measurement (i_measurement),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_drive       (o_drive),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // controller image: settings and loop state
    logic [pdgc_pkg::GAIN_W-1:0]         gain_p = '0;
    logic [pdgc_pkg::GAIN_W-1:0]         gain_i = '0;
    logic [pdgc_pkg::GAIN_W-1:0]         gain_d = '0;
    logic signed [pdgc_pkg::DRIVE_W-1:0] lim_hi = pdgc_pkg::OUT_MAX_RST;
    logic signed [pdgc_pkg::DRIVE_W-1:0] lim_lo = pdgc_pkg::OUT_MIN_RST;
    logic [15:0]                         span = '0;
    logic signed [15:0]                  target = '0;
    logic                                running = 1'b0;
    longint                              integ = 0;
    longint                              last_err = 0;

    logic signed [pdgc_pkg::DRIVE_W-1:0] pending_drives[$];
    int                                  mismatch_count = 0;

    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    int          max_gap = 8;
    t_stall_mode stall_mode = STALL_NONE;
    bit          hold_toggle = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_left = 0;
    int unsigned rx_cycle = 0;

    function automatic longint trunc_quot(longint num, logic [pdgc_pkg::GAIN_W-1:0] den);
        if (den == 0)
            return 0;
        return num / longint'(den);
    endfunction

    function automatic logic signed [pdgc_pkg::DRIVE_W-1:0] predict_drive(
        logic signed [15:0] meas);
        longint err, wspan, trial, prod, drive;
        longint sum_hi, sum_lo;
        sum_hi = 64'sd2147483647;
        sum_lo = -sum_hi - 1;
        if (!running)
            return '0;
        err = longint'(target) - longint'(meas);
        wspan = longint'(span);
        // continuous input: fold errors beyond half the span
        if ((err < 0 ? -err : err) > wspan / 2)
            err = (err > 0) ? err - wspan : err + wspan;
        trial = integ + err;
        prod = trial * longint'(gain_i);
        if (prod < longint'(lim_hi) && prod > longint'(lim_lo)) begin
            if (trial > sum_hi) trial = sum_hi;
            if (trial < sum_lo) trial = sum_lo;
            integ = trial;
        end
        drive = trunc_quot(err, gain_p) + trunc_quot(integ, gain_i)
              + trunc_quot(err - last_err, gain_d);
        last_err = err;
        if (drive > longint'(lim_hi))
            drive = longint'(lim_hi);
        else if (drive < longint'(lim_lo))
            drive = longint'(lim_lo);
        return drive[pdgc_pkg::DRIVE_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_drive(logic signed [pdgc_pkg::DRIVE_W-1:0] got);
        logic signed [pdgc_pkg::DRIVE_W-1:0] want;
        if (pending_drives.size() == 0) begin
            report_mismatch($sformatf("drive %0d with no request pending", got));
        end else begin
            want = pending_drives.pop_front();
            if (got !== want)
                report_mismatch($sformatf("drive %0d, expected %0d", got, want));
        end
    endtask

    // result side: checks every accepted drive and stalls on its own pattern
    always @(posedge i_clk) begin : drive_monitor
        logic pattern_stall;
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_drive(o_drive);
        case (stall_mode)
            STALL_RANDOM:   pattern_stall = ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: pattern_stall = ((rx_cycle % 11) < 4);
            default:        pattern_stall = 1'b0;
        endcase
        rx_cycle <= rx_cycle + 1;
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        i_out_stall <= pattern_stall || (hold_left > 1) || (hold_toggle != hold_seen);
    end

    task automatic write_reg(logic [pdgc_pkg::CFG_IDX_W-1:0] idx,
                             logic [pdgc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pdgc_pkg::REG_KP:     gain_p = data[pdgc_pkg::GAIN_W-1:0];
            pdgc_pkg::REG_KI:     gain_i = data[pdgc_pkg::GAIN_W-1:0];
            pdgc_pkg::REG_KD:     gain_d = data[pdgc_pkg::GAIN_W-1:0];
            pdgc_pkg::REG_OUTMAX: lim_hi = data;
            pdgc_pkg::REG_OUTMIN: lim_lo = data;
            pdgc_pkg::REG_SPAN:   span = data;
            pdgc_pkg::REG_SETPT:  target = data;
            pdgc_pkg::REG_RUN:    running = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // top bit of the gain data is junk that the block must drop
    task automatic load_settings(logic [pdgc_pkg::GAIN_W-1:0] kp,
                                 logic [pdgc_pkg::GAIN_W-1:0] ki,
                                 logic [pdgc_pkg::GAIN_W-1:0] kd, logic signed [15:0] hi,
                                 logic signed [15:0] lo, logic [15:0] sp_span,
                                 logic signed [15:0] sp, logic run);
        write_reg(pdgc_pkg::REG_KP, {1'($urandom_range(0, 1)), kp});
        write_reg(pdgc_pkg::REG_KI, {1'($urandom_range(0, 1)), ki});
        write_reg(pdgc_pkg::REG_KD, {1'($urandom_range(0, 1)), kd});
        write_reg(pdgc_pkg::REG_OUTMAX, hi);
        write_reg(pdgc_pkg::REG_OUTMIN, lo);
        write_reg(pdgc_pkg::REG_SPAN, sp_span);
        write_reg(pdgc_pkg::REG_SETPT, sp);
        write_reg(pdgc_pkg::REG_RUN, {15'd0, run});
    endtask

    task automatic send_measurement(logic signed [15:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, max_gap) : 0;
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_measurement <= value;
        do @(posedge i_clk); while (o_in_stall);
        pending_drives.push_back(predict_drive(value));
    endtask

    // every request yields a drive, so an empty queue means the block is idle
    task automatic end_requests();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_drives.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [pdgc_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 15'd1;
            2: return 15'($urandom_range(2, 16));
            3: return 15'($urandom_range(17, 400));
            4: return 15'($urandom_range(401, 32766));
            default: return 15'h7FFF;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_measurement();
        case ($urandom_range(0, 5))
            0, 1, 2: return target + 16'($urandom_range(0, 256)) - 16'sd128;
            3: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_random_settings(logic run);
        logic signed [15:0] hi, lo, sp;
        logic [15:0]        sp_span;
        case ($urandom_range(0, 3))
            0: begin hi = 16'sh7FFF; lo = 16'sh8000; end
            1: begin hi = 16'($urandom_range(1, 32767)); lo = -hi; end
            2: begin hi = 16'($urandom_range(0, 300)); lo = -16'($urandom_range(0, 300)); end
            default: begin hi = 16'($urandom); lo = 16'($urandom); end
        endcase
        case ($urandom_range(0, 3))
            0: sp_span = '0;
            1: sp_span = 16'hFFFF;
            2: sp_span = 16'($urandom_range(1, 2000));
            default: sp_span = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: sp = '0;
            1: sp = 16'sh8000;
            2: sp = 16'sh7FFF;
            default: sp = 16'($urandom);
        endcase
        load_settings(pick_gain(), pick_gain(), pick_gain(), hi, lo, sp_span, sp, run);
    endtask

    task automatic test_disabled_after_reset();
        send_measurement(16'sh7FFF);
        send_measurement(16'sh8000);
        send_measurement(16'sh0000);
        end_requests();
    endtask

    task automatic test_proportional_extremes();
        load_settings(15'd1, 15'd0, 15'd0, 16'sh7FFF, 16'sh8000, 16'h0000, 16'sh0000, 1'b1);
        send_measurement(16'sh8000);
        send_measurement(16'sh7FFF);
        send_measurement(16'sh0001);
        send_measurement(16'shFFFF);
        end_requests();
    endtask

    task automatic test_zero_divisors();
        load_settings(15'd0, 15'd0, 15'd0, 16'sh7FFF, 16'sh8000, 16'h0000, 16'sh1234, 1'b1);
        send_measurement(16'sh8000);
        end_requests();
    endtask

    task automatic test_continuous_wrap();
        load_settings(15'd1, 15'd0, 15'd1, 16'sh7FFF, 16'sh8000, 16'd1000, 16'sh0000, 1'b1);
        send_measurement(-16'sd800);
        send_measurement(16'sd800);
        send_measurement(16'sd500);
        end_requests();
        // widest span with the largest possible error
        write_reg(pdgc_pkg::REG_SPAN, 16'hFFFF);
        write_reg(pdgc_pkg::REG_SETPT, 16'h8000);
        send_measurement(16'sh7FFF);
        send_measurement(16'sh8000);
        end_requests();
    endtask

    task automatic test_crossed_limits();
        load_settings(15'd1, 15'd0, 15'd0, -16'sd10, 16'sd10, 16'h0000, 16'sh0000, 1'b1);
        send_measurement(-16'sd1000);
        send_measurement(16'sd1000);
        send_measurement(16'sh0000);
        end_requests();
    endtask

    task automatic test_windup_limit();
        load_settings(15'd0, 15'd3, 15'd0, 16'sd127, -16'sd127, 16'h0000, 16'sh0000, 1'b1);
        repeat (4) send_measurement(-16'sd20);
        end_requests();
        write_reg(pdgc_pkg::REG_KD, 16'd2);
        send_measurement(16'sd15);
        end_requests();
        // zero ki with zero on a limit: integral must not move
        write_reg(pdgc_pkg::REG_KI, 16'd0);
        write_reg(pdgc_pkg::REG_OUTMIN, 16'd0);
        send_measurement(-16'sd5);
        end_requests();
    endtask

    task automatic test_register_masking();
        write_reg(pdgc_pkg::REG_KP, 16'hFFFF);
        write_reg(pdgc_pkg::REG_RUN, 16'h0002);
        repeat (3) write_reg(4'($urandom_range(8, 15)), 16'($urandom));
        send_measurement(16'sh4000);
        send_measurement(-16'sh4000);
        end_requests();
        write_reg(pdgc_pkg::REG_RUN, 16'h0003);
        send_measurement(16'sh2000);
        end_requests();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0)
                load_settings(15'h7FFF, 15'h7FFF, 15'h7FFF, 16'sh7FFF, 16'sh8000,
                              16'hFFFF, 16'sh8000, 1'b1);
            else if (phase == 1)
                load_settings(15'd1, 15'd1, 15'd1, 16'sh7FFF, 16'sh8000,
                              16'h0000, 16'sh7FFF, 1'b1);
            else
                load_random_settings(phase != 5);
            if ($urandom_range(0, 2) == 0)
                write_reg(4'($urandom_range(8, 15)), 16'($urandom));
            stall_mode <= t_stall_mode'(phase % 3);
            gaps_on = (phase % 4 != 3);
            max_gap = (phase % 2 != 0) ? 150 : 8;
            repeat (PHASE_ITEMS) send_measurement(pick_measurement());
            end_requests();
        end
    endtask

    // result side holds off long enough for the block to back up its input
    task automatic test_output_hold_off();
        load_random_settings(1'b1);
        gaps_on = 1'b0;
        stall_mode <= STALL_NONE;
        hold_toggle <= ~hold_toggle;
        repeat (40) send_measurement(pick_measurement());
        end_requests();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled_after_reset();
        test_proportional_extremes();
        test_zero_divisors();
        test_continuous_wrap();
        test_crossed_limits();
        test_windup_limit();
        test_register_masking();
        test_random_settings();
        test_output_hold_off();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #16_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
